// ----- design/lsvw_pkg.sv -----
// Shared types and constants for the line segment voxel walker.
// No dependencies; every other design file imports this package.
`default_nettype none

package lsvw_pkg;

	localparam int COORD_W  = 24;
	localparam int AD_W     = COORD_W + 1;
	localparam int NUM_W    = 31;
	localparam int PROD_W   = NUM_W + AD_W;
	localparam int DIV_STEPS = COORD_W;

	localparam logic [2:0] SEL_START_X = 3'd0;
	localparam logic [2:0] SEL_START_Y = 3'd1;
	localparam logic [2:0] SEL_START_Z = 3'd2;
	localparam logic [2:0] SEL_END_X   = 3'd3;
	localparam logic [2:0] SEL_END_Y   = 3'd4;
	localparam logic [2:0] SEL_END_Z   = 3'd5;

	localparam logic [COORD_W-1:0] VSIZE_RESET = 24'd4096;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] voxel_x;
		logic signed [COORD_W-1:0] voxel_y;
		logic signed [COORD_W-1:0] voxel_z;
		logic                      last;
		logic                      truncated;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic [2:0] div_sel;
		logic       emit_first;
		logic       mul;
		logic       step;
		logic       last;
		logic       truncated;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic same;
		logic hit_end;
		logic same_next;
	} stat_t;

endpackage

`default_nettype wire

// ----- design/lsvw_div.sv -----
// Iterative floor divider, one quotient bit per cycle.
// Depends on lsvw_pkg for the coordinate width.
`default_nettype none

module lsvw_div import lsvw_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic signed [COORD_W-1:0] dividend,
	input  wire logic        [COORD_W-1:0] divisor,
	output logic                           done,
	output logic signed [COORD_W-1:0]      quot,
	output logic        [COORD_W-1:0]      rem
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COORD_W-1:0] mag_q;
	logic [COORD_W-1:0] rem_q;
	logic               neg_q;
	logic [COORD_W:0]   remsh;
	logic [COORD_W:0]   remsub;
	logic               ge;
	logic               rnz;

	assign remsh  = {rem_q, mag_q[COORD_W-1]};
	assign ge     = remsh >= {1'b0, divisor};
	assign remsub = remsh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= dividend[COORD_W-1];
			mag_q <= dividend[COORD_W-1] ? -dividend : dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[COORD_W-2:0], ge};
			rem_q <= ge ? remsub[COORD_W-1:0] : remsh[COORD_W-1:0];
		end
	end

	assign rnz  = rem_q != '0;
	assign done = done_q;
	assign quot = neg_q ? (rnz ? ~mag_q : -mag_q) : mag_q;
	assign rem  = (neg_q && rnz) ? divisor - rem_q : rem_q;

endmodule

`default_nettype wire

// ----- design/lsvw_dp.sv -----
// Datapath: voxel size register, setup divisions, border times and voxel stepping.
// Depends on lsvw_pkg and instantiates lsvw_div.
`default_nettype none

module lsvw_dp import lsvw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [COORD_W-1:0] cfg_data,
	input  wire item_t              item,
	input  wire cmd_t               cmd,
	output stat_t                   st,
	output logic                    result_valid,
	output result_t                 result
);

	logic [COORD_W-1:0]        vsize_q;
	logic [COORD_W-1:0]        s;
	item_t                     item_q;
	logic signed [COORD_W-1:0] cur_q [3];
	logic signed [COORD_W-1:0] endv_q [3];
	logic [NUM_W-1:0]          num_q [3];
	logic [AD_W-1:0]           ad_q [3];
	logic                      pos_q [3];
	logic                      vld_q [3];
	logic [PROD_W-1:0]         prod_s1 [6];
	logic signed [COORD_W-1:0] dividend;
	logic                      div_done;
	logic signed [COORD_W-1:0] quot;
	logic [COORD_W-1:0]        rem;
	logic signed [COORD_W:0]   d [3];
	logic                      lt_yx, lt_zx, lt_zy;
	logic                      m1_none, m_none;
	logic [1:0]                m1, m;
	logic                      outside;
	logic signed [COORD_W-1:0] nxt [3];
	result_t                   result_q;
	logic                      result_valid_q;

	assign s = (vsize_q == '0) ? COORD_W'(1) : vsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsize_q <= VSIZE_RESET;
		end else if (cfg_we) begin
			vsize_q <= cfg_data;
		end
	end

	always_comb begin
		d[0] = $signed({item.end_x[COORD_W-1], item.end_x})
			- $signed({item.start_x[COORD_W-1], item.start_x});
		d[1] = $signed({item.end_y[COORD_W-1], item.end_y})
			- $signed({item.start_y[COORD_W-1], item.start_y});
		d[2] = $signed({item.end_z[COORD_W-1], item.end_z})
			- $signed({item.start_z[COORD_W-1], item.start_z});
	end

	always_comb begin
		case (cmd.div_sel)
			SEL_START_X: dividend = item_q.start_x;
			SEL_START_Y: dividend = item_q.start_y;
			SEL_START_Z: dividend = item_q.start_z;
			SEL_END_X:   dividend = item_q.end_x;
			SEL_END_Y:   dividend = item_q.end_y;
			SEL_END_Z:   dividend = item_q.end_z;
			default:     dividend = item_q.start_x;
		endcase
	end

	lsvw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_start),
		.dividend (dividend),
		.divisor  (s),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign lt_yx = prod_s1[0] < prod_s1[1];
	assign lt_zx = prod_s1[2] < prod_s1[3];
	assign lt_zy = prod_s1[4] < prod_s1[5];

	always_comb begin
		m1_none = 1'b0;
		m1      = 2'd0;
		if (vld_q[0] && !(vld_q[1] && lt_yx)) begin
			m1 = 2'd0;
		end else if (vld_q[1]) begin
			m1 = 2'd1;
		end else begin
			m1_none = 1'b1;
		end
		m      = m1;
		m_none = m1_none;
		if (vld_q[2] && (m1_none || (m1 == 2'd0 ? lt_zx : lt_zy))) begin
			m      = 2'd2;
			m_none = 1'b0;
		end
	end

	always_comb begin
		nxt[0] = cur_q[0];
		nxt[1] = cur_q[1];
		nxt[2] = cur_q[2];
		nxt[m] = pos_q[m] ? cur_q[m] + COORD_W'(1) : cur_q[m] - COORD_W'(1);
	end

	assign outside = cur_q[m] == endv_q[m];

	assign st.div_done  = div_done;
	assign st.same      = cur_q[0] == endv_q[0] && cur_q[1] == endv_q[1]
		&& cur_q[2] == endv_q[2];
	assign st.hit_end   = m_none || outside;
	assign st.same_next = nxt[0] == endv_q[0] && nxt[1] == endv_q[1]
		&& nxt[2] == endv_q[2];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			for (int i = 0; i < 3; i++) begin
				vld_q[i] <= d[i] != '0;
				pos_q[i] <= !d[i][COORD_W] && d[i] != '0;
				ad_q[i]  <= d[i][COORD_W] ? AD_W'(-d[i]) : AD_W'(d[i]);
			end
		end
		if (div_done) begin
			if (cmd.div_sel < SEL_END_X) begin
				cur_q[cmd.div_sel[1:0]] <= quot;
				num_q[cmd.div_sel[1:0]] <= pos_q[cmd.div_sel[1:0]]
					? NUM_W'(s - rem) : NUM_W'(rem);
			end else begin
				endv_q[2'(cmd.div_sel - SEL_END_X)] <= quot;
			end
		end
		if (cmd.mul) begin
			prod_s1[0] <= num_q[1] * ad_q[0];
			prod_s1[1] <= num_q[0] * ad_q[1];
			prod_s1[2] <= num_q[2] * ad_q[0];
			prod_s1[3] <= num_q[0] * ad_q[2];
			prod_s1[4] <= num_q[2] * ad_q[1];
			prod_s1[5] <= num_q[1] * ad_q[2];
		end
		if (cmd.step && !st.hit_end) begin
			cur_q[m] <= nxt[m];
			num_q[m] <= num_q[m] + NUM_W'(s);
		end
		if (cmd.emit_first) begin
			result_q.voxel_x   <= cur_q[0];
			result_q.voxel_y   <= cur_q[1];
			result_q.voxel_z   <= cur_q[2];
			result_q.last      <= cmd.last;
			result_q.truncated <= cmd.truncated;
		end else if (cmd.step) begin
			result_q.voxel_x   <= st.hit_end ? endv_q[0] : nxt[0];
			result_q.voxel_y   <= st.hit_end ? endv_q[1] : nxt[1];
			result_q.voxel_z   <= st.hit_end ? endv_q[2] : nxt[2];
			result_q.last      <= cmd.last;
			result_q.truncated <= cmd.truncated;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit_first || cmd.step;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- design/lsvw_ctrl.sv -----
// Controller state machine: sequences setup divisions and voxel steps, counts beats.
// Depends on lsvw_pkg for the command and status types.
`default_nettype none

module lsvw_ctrl import lsvw_pkg::*; #(
	parameter int MAX_VOXELS = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire stat_t st,
	output cmd_t       cmd
);

	localparam int CNT_W = $clog2(MAX_VOXELS + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DIVGO   = 3'd1;
	localparam logic [2:0] S_DIVWAIT = 3'd2;
	localparam logic [2:0] S_FIRST   = 3'd3;
	localparam logic [2:0] S_MUL     = 3'd4;
	localparam logic [2:0] S_STEP    = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [2:0]       sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic             at_limit;
	logic             done_now;

	assign at_limit = cnt_q == CNT_W'(MAX_VOXELS - 1);

	always_comb begin
		cmd          = '0;
		cmd.div_sel  = sel_q;
		state_d      = state_q;
		done_now     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DIVGO;
				end
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVWAIT;
			end
			S_DIVWAIT: begin
				if (st.div_done) begin
					state_d = (sel_q == SEL_END_Z) ? S_FIRST : S_DIVGO;
				end
			end
			S_FIRST: begin
				done_now       = st.same;
				cmd.emit_first = 1'b1;
				cmd.last       = done_now || at_limit;
				cmd.truncated  = cmd.last && !done_now;
				state_d        = cmd.last ? S_IDLE : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				done_now      = st.hit_end || st.same_next;
				cmd.step      = 1'b1;
				cmd.last      = done_now || at_limit;
				cmd.truncated = cmd.last && !done_now;
				state_d       = cmd.last ? S_IDLE : S_MUL;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= SEL_START_X;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				sel_q <= SEL_START_X;
				cnt_q <= '0;
			end
			if (state_q == S_DIVWAIT && st.div_done) begin
				sel_q <= sel_q + 3'd1;
			end
			if (cmd.emit_first || cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = state_q != S_IDLE;

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_first || cmd.step) && cmd.last |=> state_q == S_IDLE)
		else $error("walk did not end after the last beat");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VOXELS))
		else $error("beat count beyond limit");

	a_limit_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_first || cmd.step) && at_limit |-> cmd.last)
		else $error("beat at limit not marked last");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> state_q == S_DIVWAIT)
		else $error("divider finished outside of a wait");

endmodule

`default_nettype wire

// ----- design/line_segment_voxel_walker.sv -----
// Line segment voxel walker: a 3D DDA that lists the voxels a segment crosses.
// A segment takes six setup divisions on one shared bit-serial divider, then
// emits the start voxel and, for each further voxel, forms cross products,
// then compares and steps; busy falls in the cycle that presents the last
// beat. Result beats appear for one cycle with result_valid and cannot be
// stalled. Depends on lsvw_pkg, lsvw_ctrl, lsvw_dp.
`default_nettype none

module line_segment_voxel_walker import lsvw_pkg::*; #(
	parameter int MAX_VOXELS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire item_t              item,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [COORD_W-1:0] cfg_data,
	output logic                    result_valid,
	output result_t                 result
);

	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = !busy;

	lsvw_ctrl #(
		.MAX_VOXELS (MAX_VOXELS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	lsvw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.st           (st),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire
